// ===== hdl/assert_macros.svh =====
// Assertion macros used by the top-level core module of the count table block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of aclk while reset is released.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Checked on every rising edge of aclk, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

// ===== hdl/aact_pkg.sv =====
// Package with types, constants and codes of the allele ancestry count table.
`default_nettype none

package aact_pkg;

    localparam int LOCI       = 1024;
    localparam int MAX_STATES = 16;
    localparam int MAX_POPS   = 8;

    localparam int ALLELE_DEPTH = LOCI * MAX_STATES * MAX_POPS;
    localparam int HET_DEPTH    = LOCI * MAX_POPS * MAX_POPS;
    localparam int AW           = $clog2(ALLELE_DEPTH);
    localparam int HW           = $clog2(HET_DEPTH);
    localparam int CNT_W        = 32;
    localparam int CFG_IDX_W    = 4;
    localparam int CFG_DATA_W   = 4;

    // Input item kinds.
    localparam logic [1:0] KIND_EVENT  = 2'd0;
    localparam logic [1:0] KIND_CLEAR  = 2'd1;
    localparam logic [1:0] KIND_READ_A = 2'd2;
    localparam logic [1:0] KIND_READ_H = 2'd3;

    // Result outcomes.
    localparam logic [2:0] OUT_IGNORED = 3'd0;
    localparam logic [2:0] OUT_ONE     = 3'd1;
    localparam logic [2:0] OUT_TWO     = 3'd2;
    localparam logic [2:0] OUT_HET     = 3'd3;
    localparam logic [2:0] OUT_DONE    = 3'd4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_POPULATIONS  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLER_MODE = 4'd1;

    typedef struct packed {
        logic [1:0] kind;
        logic [9:0] locus;
        logic [4:0] num_states;
        logic [3:0] allele_first;
        logic [3:0] allele_second;
        logic [2:0] ancestry_first;
        logic [2:0] ancestry_second;
        logic       diploid;
        logic       anneal;
    } in_item_t;

    typedef struct packed {
        logic [2:0]       outcome;
        logic [CNT_W-1:0] read_count;
    } out_item_t;

    typedef enum logic [2:0] {
        OP_IGNORE,
        OP_CLEAR,
        OP_READ_A,
        OP_READ_H,
        OP_INC_H,
        OP_INC_ONE,
        OP_INC_TWO
    } op_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_UPDATE,
        ST_RESULT
    } state_t;

    // Commands from the sequencer to the table memories.
    typedef struct packed {
        logic          rd_en;
        logic          wr_en;
        logic          clear;
        logic          sel_het;
        logic [AW-1:0] addr;
    } tbl_ctrl_t;

endpackage

`default_nettype wire

// ===== hdl/allele_ancestry_count_table_core.sv =====
// Top level of the allele ancestry count table: decode, sequencer and result register.
`default_nettype none

// Each word on s_ is one command; each produces exactly one word on m_. An ignored command
// goes straight to the result step, a read or a single count takes one read and one update
// step, a double count two of each (every increment is a read-modify-write through the
// one incrementer and one port per table), and a clear walks all 131072 allele entries,
// clearing the het table alongside. Any command is held longer while the previous result
// word still waits for m_ready. After reset the same clearing pass runs, during which
// s_ready stays low; configuration writes are taken in every state.
`include "assert_macros.svh"

module allele_ancestry_count_table_core
    import aact_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire in_item_t              s_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output out_item_t                  m_data,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    state_t           state_reg, state_next;
    op_t              op_reg, dec_op;
    logic [AW-1:0]    addr1_reg, addr2_reg, dec_addr1, dec_addr2;
    logic [2:0]       outcome_reg, dec_outcome;
    logic             second_reg;
    logic             reply_reg;
    logic [AW-1:0]    clr_cnt_reg;
    logic [CNT_W-1:0] count_reg;
    logic [3:0]       pop_reg;
    logic             mode_reg;
    logic             m_valid_reg;
    out_item_t        m_data_reg;
    tbl_ctrl_t        ctrl;
    logic [CNT_W-1:0] rd_data;
    logic             accept;
    logic             out_load;

    aact_tables u_tables (
        .aclk    (aclk),
        .ctrl    (ctrl),
        .rd_data (rd_data)
    );

    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pop_reg  <= 4'd2;
            mode_reg <= 1'b0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_POPULATIONS:  pop_reg  <= cfg_data;
                REG_SAMPLER_MODE: mode_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Command decode.
    always_comb begin
        logic [3:0] k;
        logic       locus_ok, ns_ok, a0_ok, a1_ok, h0_ok, h1_ok;
        logic       het;
        logic [1:0] pairs;

        k        = (pop_reg > 4'(MAX_POPS)) ? 4'(MAX_POPS) : pop_reg;
        locus_ok = {1'b0, s_data.locus} < 11'(LOCI);
        ns_ok    = (s_data.num_states >= 5'd2) && (s_data.num_states <= 5'(MAX_STATES));
        a0_ok    = {1'b0, s_data.ancestry_first} < k;
        a1_ok    = {1'b0, s_data.ancestry_second} < k;
        h0_ok    = {1'b0, s_data.allele_first} < s_data.num_states;
        h1_ok    = {1'b0, s_data.allele_second} < s_data.num_states;
        het      = 1'b0;
        pairs    = 2'd0;

        dec_op      = OP_IGNORE;
        dec_outcome = OUT_IGNORED;
        dec_addr1   = {s_data.locus, s_data.allele_first, s_data.ancestry_first};
        dec_addr2   = {s_data.locus, s_data.allele_second, s_data.ancestry_second};

        if (mode_reg == 1'b0) begin
            pairs = s_data.diploid ? 2'd2 : 2'd1;
        end else if (s_data.diploid) begin
            if (s_data.num_states == 5'd2) begin
                if (s_data.allele_first != s_data.allele_second
                    && s_data.ancestry_first != s_data.ancestry_second) begin
                    het = 1'b1;
                end else begin
                    pairs = 2'd2;
                end
            end else if (!s_data.anneal) begin
                pairs = 2'd2;
            end
        end else if (s_data.num_states == 5'd2 || !s_data.anneal) begin
            pairs = 2'd1;
        end

        unique case (s_data.kind)
            KIND_CLEAR: begin
                dec_op      = OP_CLEAR;
                dec_outcome = OUT_DONE;
            end
            KIND_READ_A: begin
                if (locus_ok && ({1'b0, s_data.allele_first} < 5'(MAX_STATES)) && a0_ok) begin
                    dec_op      = OP_READ_A;
                    dec_outcome = OUT_DONE;
                end
            end
            KIND_READ_H: begin
                dec_addr1 = AW'({s_data.locus, s_data.ancestry_first, s_data.ancestry_second});
                if (locus_ok && a0_ok && a1_ok) begin
                    dec_op      = OP_READ_H;
                    dec_outcome = OUT_DONE;
                end
            end
            default: begin
                if (locus_ok && ns_ok) begin
                    if (het) begin
                        dec_addr1 = AW'({s_data.locus, s_data.ancestry_first,
                                         s_data.ancestry_second});
                        if (h0_ok && h1_ok && a0_ok && a1_ok) begin
                            dec_op      = OP_INC_H;
                            dec_outcome = OUT_HET;
                        end
                    end else if (pairs == 2'd2) begin
                        if (h0_ok && a0_ok && h1_ok && a1_ok) begin
                            dec_op      = OP_INC_TWO;
                            dec_outcome = OUT_TWO;
                        end
                    end else if (pairs == 2'd1) begin
                        if (h0_ok && a0_ok) begin
                            dec_op      = OP_INC_ONE;
                            dec_outcome = OUT_ONE;
                        end
                    end
                end
            end
        endcase
    end

    // Sequencer: next state and memory commands.
    always_comb begin
        state_next   = state_reg;
        s_ready      = 1'b0;
        ctrl         = '0;
        ctrl.addr    = addr1_reg;
        ctrl.sel_het = (op_reg == OP_READ_H) || (op_reg == OP_INC_H);
        out_load     = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                ctrl.clear = 1'b1;
                ctrl.addr  = clr_cnt_reg;
                if (clr_cnt_reg == AW'(ALLELE_DEPTH - 1)) begin
                    state_next = reply_reg ? ST_RESULT : ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    unique case (dec_op)
                        OP_CLEAR:  state_next = ST_CLEAR;
                        OP_IGNORE: state_next = ST_RESULT;
                        default:   state_next = ST_READ;
                    endcase
                end
            end
            ST_READ: begin
                ctrl.rd_en = 1'b1;
                state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                ctrl.wr_en = (op_reg == OP_INC_H) || (op_reg == OP_INC_ONE)
                             || (op_reg == OP_INC_TWO);
                state_next = second_reg ? ST_READ : ST_RESULT;
            end
            ST_RESULT: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign accept = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
        end else begin
            state_reg   <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
            reply_reg   <= 1'b0;
            second_reg  <= 1'b0;
            op_reg      <= OP_IGNORE;
            m_valid_reg <= 1'b0;
        end else begin
            if (state_reg == ST_CLEAR) begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
            if (accept) begin
                op_reg      <= dec_op;
                second_reg  <= (dec_op == OP_INC_TWO);
                reply_reg   <= 1'b1;
                clr_cnt_reg <= '0;
            end else if (state_reg == ST_UPDATE && second_reg) begin
                second_reg <= 1'b0;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            addr1_reg   <= dec_addr1;
            addr2_reg   <= dec_addr2;
            outcome_reg <= dec_outcome;
            count_reg   <= '0;
        end else if (state_reg == ST_UPDATE) begin
            // The second pair reuses the primary address slot for its own update.
            if (second_reg) begin
                addr1_reg <= addr2_reg;
            end
            if (op_reg == OP_READ_A || op_reg == OP_READ_H) begin
                count_reg <= rd_data;
            end
        end
        if (out_load) begin
            m_data_reg.outcome    <= outcome_reg;
            m_data_reg.read_count <= count_reg;
        end
    end

    `ASSERT_CLK(a_no_write_during_clear, !(ctrl.clear && (ctrl.wr_en || ctrl.rd_en)),
        "table write or read issued during a clearing pass")
    `ASSERT_CLK(a_write_after_read, ctrl.wr_en |-> $past(ctrl.rd_en),
        "increment written without a read in the previous cycle")
    `ASSERT_CLK(a_one_word_in_flight, accept |=> !s_ready,
        "a new word accepted before the previous one finished")
    `ASSERT_ALWAYS(a_reset_starts_clear, !aresetn |=> (state_reg == ST_CLEAR),
        "reset did not start the clearing pass")

endmodule

`default_nettype wire

// ===== hdl/aact_tables.sv =====
// Allele and het count memories with the shared saturating incrementer.
`default_nettype none

module aact_tables
    import aact_pkg::*;
(
    input  wire logic             aclk,
    input  wire tbl_ctrl_t        ctrl,
    output logic      [CNT_W-1:0] rd_data
);

    logic [CNT_W-1:0] allele_mem [ALLELE_DEPTH];
    logic [CNT_W-1:0] het_mem    [HET_DEPTH];
    logic [CNT_W-1:0] allele_q_reg;
    logic [CNT_W-1:0] het_q_reg;
    logic             sel_het_reg;
    logic [CNT_W-1:0] inc_value;

    always_comb begin
        rd_data   = sel_het_reg ? het_q_reg : allele_q_reg;
        inc_value = (rd_data == {CNT_W{1'b1}}) ? rd_data : rd_data + CNT_W'(1);
    end

    always_ff @(posedge aclk) begin
        if (ctrl.clear) begin
            allele_mem[ctrl.addr] <= '0;
        end else if (ctrl.wr_en && !ctrl.sel_het) begin
            allele_mem[ctrl.addr] <= inc_value;
        end
        if (ctrl.rd_en) begin
            allele_q_reg <= allele_mem[ctrl.addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.clear) begin
            het_mem[ctrl.addr[HW-1:0]] <= '0;
        end else if (ctrl.wr_en && ctrl.sel_het) begin
            het_mem[ctrl.addr[HW-1:0]] <= inc_value;
        end
        if (ctrl.rd_en) begin
            het_q_reg   <= het_mem[ctrl.addr[HW-1:0]];
            sel_het_reg <= ctrl.sel_het;
        end
    end

endmodule

`default_nettype wire
